// ===== rtl/ats_pkg.sv =====
// Shared types and constants for the associative LRU key table.
`default_nettype none
package ats_pkg;

  localparam int KEY_PORT_W  = 64;
  localparam int TIME_PORT_W = 32;
  localparam int SLOT_W      = 4;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef struct packed {
    logic clear;
    logic cmp;
  } scan_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/assoc_table_lru_insert_delete.sv =====
// Fully associative key table with LRU replacement by timestamp (top level).
// Each item runs a read-issue cycle, one compare per entry from the key/time memory,
//   a write-back cycle and an idle cycle; a new item is taken only in the idle state.
// A result still waiting on out_ready holds the write-back cycle.
// Reset (rst, synchronous): all valid bits clear, sequencer idle, no result.
`default_nettype none
module assoc_table_lru_insert_delete #(
  parameter int ENTRIES   = 16,
  parameter int KEY_BITS  = 64,
  parameter int TIME_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               operation,
  input  wire logic [ats_pkg::KEY_PORT_W-1:0]     key,
  input  wire logic [ats_pkg::TIME_PORT_W-1:0]    now_time,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [ats_pkg::SLOT_W-1:0]         slot,
  output logic                                    hit,
  output logic                                    evicted,
  output logic      [ats_pkg::KEY_PORT_W-1:0]     evicted_key
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W:0] LAST_CNT = (IDX_W + 1)'(ENTRIES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0]           state;
  logic [IDX_W:0]       scan_cnt;
  logic [IDX_W:0]       cnt_m1;
  logic [IDX_W-1:0]     cmp_idx;
  logic [ENTRIES-1:0]   entry_vld;
  logic                 op_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [TIME_BITS-1:0] time_q;

  ats_pkg::scan_ctl_t   ctl;
  logic [KEY_BITS-1:0]  rd_key;
  logic [TIME_BITS-1:0] rd_time;
  logic                 found;
  logic [IDX_W-1:0]     match_idx;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic [IDX_W-1:0]     min_idx;
  logic [KEY_BITS-1:0]  min_key;

  logic                 commit;
  logic                 wr_key_en;
  logic                 wr_time_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [IDX_W-1:0]     pick_idx;
  logic [IDX_W+3:0]     slot_ext;
  logic [ats_pkg::KEY_PORT_W-1:0] evk_ext;
  logic                 in_xfer;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign cnt_m1   = scan_cnt - 1'b1;
  assign cmp_idx  = cnt_m1[IDX_W-1:0];
  assign ctl.clear = in_xfer;
  assign ctl.cmp   = (state == S_SCAN) && (scan_cnt != '0);
  assign commit    = (state == S_WRITE) && (!out_valid || out_ready);
  assign pick_idx  = free_found ? free_idx : min_idx;

  always_comb begin
    wr_key_en  = 1'b0;
    wr_time_en = 1'b0;
    wr_addr    = pick_idx;
    if (commit && op_q == ats_pkg::OP_LOOKUP) begin
      if (found) begin
        wr_time_en = 1'b1;
        wr_addr    = match_idx;
      end else begin
        wr_key_en  = 1'b1;
        wr_time_en = 1'b1;
      end
    end
    slot_ext = '0;
    if (found) begin
      slot_ext[IDX_W-1:0] = match_idx;
    end else if (op_q == ats_pkg::OP_LOOKUP) begin
      slot_ext[IDX_W-1:0] = pick_idx;
    end
    evk_ext = '0;
    evk_ext[KEY_BITS-1:0] = min_key;
  end

  ats_store #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (KEY_BITS),
    .TIME_BITS (TIME_BITS),
    .IDX_W     (IDX_W)
  ) u_store (
    .clk        (clk),
    .rd_addr    (scan_cnt[IDX_W-1:0]),
    .rd_key     (rd_key),
    .rd_time    (rd_time),
    .wr_key_en  (wr_key_en),
    .wr_time_en (wr_time_en),
    .wr_addr    (wr_addr),
    .wr_key     (key_q),
    .wr_time    (time_q)
  );

  ats_scan #(
    .KEY_BITS  (KEY_BITS),
    .TIME_BITS (TIME_BITS),
    .IDX_W     (IDX_W)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .cmp_idx    (cmp_idx),
    .cmp_vld    (entry_vld[cmp_idx]),
    .rd_key     (rd_key),
    .rd_time    (rd_time),
    .key_q      (key_q),
    .found      (found),
    .match_idx  (match_idx),
    .free_found (free_found),
    .free_idx   (free_idx),
    .min_idx    (min_idx),
    .min_key    (min_key)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_cnt  <= '0;
      entry_vld <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !commit) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            op_q     <= operation;
            key_q    <= key[KEY_BITS-1:0];
            time_q   <= now_time[TIME_BITS-1:0];
            scan_cnt <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == LAST_CNT) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (commit) begin
            if (op_q == ats_pkg::OP_DELETE) begin
              if (found) begin
                entry_vld[match_idx] <= 1'b0;
              end
            end else if (!found) begin
              entry_vld[pick_idx] <= 1'b1;
            end
            out_valid <= 1'b1;
            slot      <= slot_ext[ats_pkg::SLOT_W-1:0];
            hit       <= found;
            evicted   <= (op_q == ats_pkg::OP_LOOKUP) && !found && !free_found;
            evicted_key <= ((op_q == ats_pkg::OP_LOOKUP) && !found && !free_found) ?
                           evk_ext : '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ats_store.sv =====
// Key and timestamp memories: one write port, one registered read port.
`default_nettype none
module ats_store #(
  parameter int ENTRIES   = 16,
  parameter int KEY_BITS  = 64,
  parameter int TIME_BITS = 32,
  parameter int IDX_W     = 4
) (
  input  wire logic                 clk,
  input  wire logic [IDX_W-1:0]     rd_addr,
  output logic      [KEY_BITS-1:0]  rd_key,
  output logic      [TIME_BITS-1:0] rd_time,
  input  wire logic                 wr_key_en,
  input  wire logic                 wr_time_en,
  input  wire logic [IDX_W-1:0]     wr_addr,
  input  wire logic [KEY_BITS-1:0]  wr_key,
  input  wire logic [TIME_BITS-1:0] wr_time
);

  logic [KEY_BITS-1:0]  key_mem  [ENTRIES];
  logic [TIME_BITS-1:0] time_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_key_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr_time_en) begin
      time_mem[wr_addr] <= wr_time;
    end
    rd_key  <= key_mem[rd_addr];
    rd_time <= time_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/ats_scan.sv =====
// Scan tracker: first key match, lowest free slot and oldest valid entry.
`default_nettype none
module ats_scan #(
  parameter int KEY_BITS  = 64,
  parameter int TIME_BITS = 32,
  parameter int IDX_W     = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ats_pkg::scan_ctl_t   ctl,
  input  wire logic [IDX_W-1:0]     cmp_idx,
  input  wire logic                 cmp_vld,
  input  wire logic [KEY_BITS-1:0]  rd_key,
  input  wire logic [TIME_BITS-1:0] rd_time,
  input  wire logic [KEY_BITS-1:0]  key_q,
  output logic                      found,
  output logic      [IDX_W-1:0]     match_idx,
  output logic                      free_found,
  output logic      [IDX_W-1:0]     free_idx,
  output logic      [IDX_W-1:0]     min_idx,
  output logic      [KEY_BITS-1:0]  min_key
);

  logic                 min_set;
  logic [TIME_BITS-1:0] min_time;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      found      <= 1'b0;
      free_found <= 1'b0;
      min_set    <= 1'b0;
    end else if (ctl.cmp) begin
      if (cmp_vld && !found && rd_key == key_q) begin
        found     <= 1'b1;
        match_idx <= cmp_idx;
      end
      if (!cmp_vld && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
      if (cmp_vld && (!min_set || rd_time < min_time)) begin
        min_set  <= 1'b1;
        min_time <= rd_time;
        min_idx  <= cmp_idx;
        min_key  <= rd_key;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ats_checker.sv =====
// Port-level checks for the associative LRU key table, bound to the top level.
`default_nettype none
module ats_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [ats_pkg::SLOT_W-1:0]      slot,
  input wire logic                            hit,
  input wire logic                            evicted,
  input wire logic [ats_pkg::KEY_PORT_W-1:0]  evicted_key
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(hit) &&
      $stable(evicted) && $stable(evicted_key))
    else $error("result changed while stalled");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted))
    else $error("hit and evicted both set");

  a_evk_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted |-> evicted_key == '0)
    else $error("evicted_key nonzero without eviction");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken during scan");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind assoc_table_lru_insert_delete ats_checker u_ats_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .slot        (slot),
  .hit         (hit),
  .evicted     (evicted),
  .evicted_key (evicted_key)
);
`default_nettype wire
